/* sv/ppe_pkg.sv */
`timescale 1ns / 1ps
package ppe_pkg;
  localparam int PoolCapacity = 1024;
  localparam int SlotW = 10;
  localparam int CountW = 11;
  localparam int QOne = 65536;
  localparam int HalfQ = 32768;

  localparam logic [1:0] OP_SPAWN = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;

  localparam logic [2:0] REG_GRAV_X = 3'd0;
  localparam logic [2:0] REG_GRAV_Y = 3'd1;
  localparam logic [2:0] REG_GRAV_Z = 3'd2;
  localparam logic [2:0] REG_GROUND = 3'd3;
  localparam logic [2:0] REG_DAMPING = 3'd4;
  localparam logic [2:0] REG_START_COLOR = 3'd5;
  localparam logic [2:0] REG_END_COLOR = 3'd6;
  localparam logic [2:0] REG_POOL_LIMIT = 3'd7;

  // One particle record as held in the slot memory.
  typedef struct packed {
    logic [63:0] color;
    logic [31:0] full_life;
    logic [31:0] life;
    logic [31:0] vel_z;
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] pos_z;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } particle_t;

  localparam int ParticleW = $bits(particle_t);

  // Operation codes of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_MUL_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } alu_req_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage

/* sv/particle_pool_euler_update.sv */
`timescale 1ns / 1ps
// Channel | Direction | Contents
// in_     | slave     | tdata: opcode, slot_index, start_pos_x/y/z, start_vel_x/y/z,
//         |           |        lifetime, time_step
// out_    | master    | tdata: status, live_count, out_pos_x/y/z, out_vel_x/y/z,
//         |           |        out_life, out_color
// cfg_    | slave     | register index and write data
//
// After the input transfer every item, refused or not, gives one result on out_.
// A tick walks the live particles in turn; a particle whose color needs it
// waits on the one-bit-per-cycle divider, and a dying one is swap-removed.
// Reset clears the count and sets the registers to their defaults; the slot memory is not cleared.
// The input is not ready while an item is at work or its result waits.
module particle_pool_euler_update (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] opcode, [11:2] slot_index, [43:12] start_pos_x, [75:44] start_pos_y,
  // [107:76] start_pos_z, [139:108] start_vel_x, [171:140] start_vel_y,
  // [203:172] start_vel_z, [234:204] lifetime, [265:235] time_step, rest zero
  input  logic [271:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [12:2] live_count, [44:13] out_pos_x, [76:45] out_pos_y,
  // [108:77] out_pos_z, [140:109] out_vel_x, [172:141] out_vel_y,
  // [204:173] out_vel_z, [236:205] out_life, [300:237] out_color, rest zero
  output logic [303:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_LIFE, S_VX, S_VY, S_VZ, S_PX, S_PY, S_PZ,
    S_BOUNCE, S_DIV, S_COLOR, S_WRITE, S_MOVE, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] grav_x_r, grav_y_r, grav_z_r, ground_r;
  logic [16:0] damp_r;
  logic [63:0] scol_r, ecol_r;
  logic [10:0] limit_r;
  logic [10:0] count_r;
  logic [10:0] idx_r;
  logic [1:0]  op_r;
  logic [30:0] dt_r;
  logic [1:0]  status_r;
  logic        out_valid_r;
  logic [303:0] out_data_r;
  ppe_pkg::particle_t p_r, rd_data, wr_data;
  logic        we;
  logic [9:0]  waddr, raddr_r;
  ppe_pkg::alu_req_t req;
  logic [31:0] alu_res;
  logic        div_start;
  logic        div_done;
  logic [16:0] div_q;
  logic [16:0] t_r;
  logic [10:0] lim;
  logic [31:0] vy_raw;

  ppe_ram #(.Width(ppe_pkg::ParticleW), .Depth(ppe_pkg::PoolCapacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_data),
    .raddr(raddr_r), .rdata(rd_data)
  );

  ppe_alu u_alu (.clk(clk), .req(req), .res_r(alu_res));

  ppe_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(p_r.life),
    .den(p_r.full_life), .done_r(div_done), .quot_r(div_q)
  );

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign lim = (limit_r > 11'(ppe_pkg::PoolCapacity)) ? 11'(ppe_pkg::PoolCapacity) : limit_r;
  assign div_start = (state_r == S_BOUNCE) && ($signed(p_r.full_life) > 0)
                     && ($signed(p_r.life) < $signed(p_r.full_life));

  // Operand selection for the shared unit; each step's result is registered and taken up in the state that follows.
  // The life step takes the record straight from the memory output.
  always_comb begin
    req = '{op: ppe_pkg::ALU_MUL, a: 32'd0, b: 32'd0, c: 32'd0};
    case (state_r)
      S_LIFE: req = '{op: ppe_pkg::ALU_SUB, a: 32'd0, b: {1'b0, dt_r}, c: rd_data.life};
      S_VX: req = '{op: ppe_pkg::ALU_MUL_ADD, a: grav_x_r, b: {1'b0, dt_r}, c: p_r.vel_x};
      S_VY: req = '{op: ppe_pkg::ALU_MUL_ADD, a: grav_y_r, b: {1'b0, dt_r}, c: p_r.vel_y};
      S_VZ: req = '{op: ppe_pkg::ALU_MUL_ADD, a: grav_z_r, b: {1'b0, dt_r}, c: p_r.vel_z};
      S_PX: req = '{op: ppe_pkg::ALU_MUL_ADD, a: p_r.vel_x, b: {1'b0, dt_r}, c: p_r.pos_x};
      S_PY: req = '{op: ppe_pkg::ALU_MUL_ADD, a: p_r.vel_y, b: {1'b0, dt_r}, c: p_r.pos_y};
      S_PZ: req = '{op: ppe_pkg::ALU_MUL_ADD, a: p_r.vel_z, b: {1'b0, dt_r}, c: p_r.pos_z};
      default: req = '{op: ppe_pkg::ALU_MUL, a: 32'd0, b: 32'd0, c: 32'd0};
    endcase
  end

  // Bounce velocity: -vy * damping, floored, saturated (-vy of min is 2^31).
  logic signed [33:0] neg_vy;
  logic signed [51:0] bprod;
  always_comb begin
    neg_vy = -$signed({{2{p_r.vel_y[31]}}, p_r.vel_y});
    bprod = neg_vy * $signed({1'b0, damp_r});
    vy_raw = ppe_pkg::sat32({{30{bprod[51]}}, bprod[51:16]});
  end

  // Color blend over the four channels with age fraction t_r.
  function automatic logic [63:0] blend(input logic [63:0] s, input logic [63:0] e,
                                        input logic [16:0] t);
    logic [63:0] r;
    logic [33:0] acc;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      acc = 34'(s[16*k +: 16] * (17'(ppe_pkg::QOne) - t)) + 34'(e[16*k +: 16] * t);
      r[16*k +: 16] = acc[31:16];
    end
    return r;
  endfunction

  always_comb begin
    we = 1'b0;
    waddr = idx_r[9:0];
    wr_data = p_r;
    if (state_r == S_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r <= '0;
      grav_x_r <= '0;
      grav_y_r <= 32'hFFF1_0000;
      grav_z_r <= '0;
      ground_r <= '0;
      damp_r <= 17'd32768;
      scol_r <= 64'hFFFF7FFF3333FFFF;
      ecol_r <= 64'h33333333FFFF0000;
      limit_r <= 11'd1000;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Configuration transfer.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppe_pkg::REG_GRAV_X: grav_x_r <= cfg_data[31:0];
          ppe_pkg::REG_GRAV_Y: grav_y_r <= cfg_data[31:0];
          ppe_pkg::REG_GRAV_Z: grav_z_r <= cfg_data[31:0];
          ppe_pkg::REG_GROUND: ground_r <= cfg_data[31:0];
          ppe_pkg::REG_DAMPING: damp_r <= cfg_data[16:0];
          ppe_pkg::REG_START_COLOR: scol_r <= cfg_data;
          ppe_pkg::REG_END_COLOR: ecol_r <= cfg_data;
          ppe_pkg::REG_POOL_LIMIT: limit_r <= cfg_data[10:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tdata[1:0];
            dt_r <= in_tdata[265:235];
            status_r <= ppe_pkg::ST_OK;
            p_r.pos_x <= in_tdata[43:12];
            p_r.pos_y <= in_tdata[75:44];
            p_r.pos_z <= in_tdata[107:76];
            p_r.vel_x <= in_tdata[139:108];
            p_r.vel_y <= in_tdata[171:140];
            p_r.vel_z <= in_tdata[203:172];
            p_r.life <= {1'b0, in_tdata[234:204]};
            p_r.full_life <= {1'b0, in_tdata[234:204]};
            p_r.color <= scol_r;
            case (in_tdata[1:0])
              ppe_pkg::OP_SPAWN: begin
                idx_r <= count_r;
                if (count_r >= lim) begin
                  status_r <= ppe_pkg::ST_FULL;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_WRITE;
                end
              end
              ppe_pkg::OP_TICK: begin
                idx_r <= '0;
                raddr_r <= '0;
                state_r <= S_RD;
              end
              ppe_pkg::OP_READ: begin
                idx_r <= {1'b0, in_tdata[11:2]};
                raddr_r <= in_tdata[11:2];
                if ({1'b0, in_tdata[11:2]} >= count_r) begin
                  status_r <= ppe_pkg::ST_NOT_LIVE;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_RD;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_RD: begin
          // Tick walk ends once the index reaches the live count.
          if (op_r == ppe_pkg::OP_TICK && idx_r >= count_r) begin
            state_r <= S_OUT;
          end else begin
            raddr_r <= idx_r[9:0];
            state_r <= S_RDW;
          end
        end
        S_RDW: begin
          state_r <= S_LIFE;
        end
        S_LIFE: begin
          p_r <= rd_data;
          if (op_r == ppe_pkg::OP_READ) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_VX;
          end
        end
        S_VX: begin
          p_r.life <= alu_res;
          if ($signed(alu_res) <= 0) begin
            // Dead: pull the last particle into this slot and redo it.
            count_r <= count_r - 11'd1;
            if (idx_r + 11'd1 < count_r) begin
              raddr_r <= 10'(count_r - 11'd1);
              state_r <= S_MOVE;
            end else begin
              state_r <= S_RD;
            end
          end else begin
            state_r <= S_VY;
          end
        end
        S_VY: begin
          p_r.vel_x <= alu_res;
          state_r <= S_VZ;
        end
        S_VZ: begin
          p_r.vel_y <= alu_res;
          state_r <= S_PX;
        end
        S_PX: begin
          p_r.vel_z <= alu_res;
          state_r <= S_PY;
        end
        S_PY: begin
          p_r.pos_x <= alu_res;
          state_r <= S_PZ;
        end
        S_PZ: begin
          p_r.pos_y <= alu_res;
          state_r <= S_BOUNCE;
        end
        S_BOUNCE: begin
          p_r.pos_z <= alu_res;
          if ($signed(p_r.pos_y) <= $signed(ground_r)) begin
            p_r.pos_y <= ground_r;
            if ($signed(vy_raw) > -32'sd32768 && $signed(vy_raw) < 32'sd32768) begin
              p_r.vel_y <= '0;
            end else begin
              p_r.vel_y <= vy_raw;
            end
          end
          if ($signed(p_r.full_life) <= 0 || $signed(p_r.life) <= 0) begin
            t_r <= 17'(ppe_pkg::QOne);
            state_r <= S_COLOR;
          end else if ($signed(p_r.life) >= $signed(p_r.full_life)) begin
            t_r <= '0;
            state_r <= S_COLOR;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_r <= 17'(ppe_pkg::QOne) - div_q;
            state_r <= S_COLOR;
          end
        end
        S_COLOR: begin
          p_r.color <= blend(scol_r, ecol_r, t_r);
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (op_r == ppe_pkg::OP_SPAWN) begin
            count_r <= count_r + 11'd1;
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + 11'd1;
            state_r <= S_RD;
          end
        end
        S_MOVE: begin
          // Move the last record in, then process it at this index.
          state_r <= S_LIFE;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          if (op_r == ppe_pkg::OP_READ && status_r == ppe_pkg::ST_OK) begin
            out_data_r <= {3'b0, p_r.color, p_r.life, p_r.vel_z, p_r.vel_y,
                           p_r.vel_x, p_r.pos_z, p_r.pos_y, p_r.pos_x,
                           count_r, status_r};
          end else begin
            out_data_r <= {291'b0, count_r, status_r};
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/ppe_ram.sv */
`timescale 1ns / 1ps
module ppe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/ppe_alu.sv */
`timescale 1ns / 1ps
module ppe_alu (
  input  logic                  clk,
  input  ppe_pkg::alu_req_t     req,
  output logic [31:0]           res_r
);
  logic signed [63:0] prod;
  logic signed [65:0] wide;
  logic [31:0]        res_nxt;

  // Signed product shifted down by 16 (arithmetic shift floors), with an optional
  // accumulate, or for ALU_SUB the difference c - b; all saturated to 32 bits.
  always_comb begin
    prod = $signed(req.a) * $signed(req.b);
    wide = 66'sd0;
    case (req.op)
      ppe_pkg::ALU_MUL_ADD: begin
        wide = $signed({{18{prod[63]}}, prod[63:16]}) + $signed({{34{req.c[31]}}, req.c});
      end
      ppe_pkg::ALU_SUB: begin
        wide = $signed({{34{req.c[31]}}, req.c}) - $signed({{34{req.b[31]}}, req.b});
      end
      ppe_pkg::ALU_MUL: begin
        wide = $signed({{18{prod[63]}}, prod[63:16]});
      end
      default: begin
        wide = 66'sd0;
      end
    endcase
    res_nxt = ppe_pkg::sat32(wide);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end
endmodule

/* sv/ppe_div.sv */
`timescale 1ns / 1ps
module ppe_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done_r,
  output logic [16:0] quot_r
);
  // Restoring division of num*65536 by den; num < den so the quotient
  // has 16 bits. One quotient bit per cycle.
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [33:0] trial;

  always_comb begin
    trial = {rem_r, 1'b0} - {2'b00, den_r};
    rem_nxt = trial[33] ? {rem_r[31:0], 1'b0} : trial[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 5'd16;
        rem_r <= {1'b0, num};
        den_r <= den;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quot_r <= {quot_r[15:0], ~trial[33]};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  localparam longint CycleLimit = 4000000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [271:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [303:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  particle_pool_euler_update dut (.*);

  // One item on the input channel.
  typedef struct {
    logic [1:0]  op;
    logic [9:0]  slot;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [30:0] lt, dt;
    bit          has_exp;
    logic [1:0]  st;
    int          cnt;
  } stim_row_t;

  // One result as the block should return it.
  typedef struct {
    logic [1:0]  status;
    logic [10:0] live_count;
    logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life;
    logic [63:0] color;
  } particle_reply_t;

  // Mirror of the pool and its registers.
  int          grav_x, grav_y, grav_z, ground;
  int unsigned damping, limit_reg;
  logic [63:0] color_birth, color_death;
  int          m_px[ppe_pkg::PoolCapacity], m_py[ppe_pkg::PoolCapacity];
  int          m_pz[ppe_pkg::PoolCapacity];
  int          m_vx[ppe_pkg::PoolCapacity], m_vy[ppe_pkg::PoolCapacity];
  int          m_vz[ppe_pkg::PoolCapacity];
  int          m_life[ppe_pkg::PoolCapacity], m_full[ppe_pkg::PoolCapacity];
  logic [63:0] m_color[ppe_pkg::PoolCapacity];
  int          live;

  particle_reply_t replies_due[$];
  int  failures;
  int  checked;
  int  n_spawn, n_tick, n_read, n_full;
  bit  hold_req;
  longint cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Q16.16 product, floored.
  function automatic longint qprod(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  // Color by age fraction.
  function automatic logic [63:0] age_color(input int life, input int full);
    longint t, s, e;
    logic [63:0] res;
    res = '0;
    if (full <= 0 || life <= 0) t = ppe_pkg::QOne;
    else if (life >= full) t = 0;
    else t = ppe_pkg::QOne - (longint'(life) * ppe_pkg::QOne) / full;
    for (int sh = 0; sh < 64; sh += 16) begin
      s = longint'(color_birth[sh +: 16]);
      e = longint'(color_death[sh +: 16]);
      res[sh +: 16] = 16'((s * (ppe_pkg::QOne - t) + e * t) >> 16);
    end
    return res;
  endfunction

  function automatic void move_particle(input int dst, input int src);
    m_px[dst] = m_px[src]; m_py[dst] = m_py[src]; m_pz[dst] = m_pz[src];
    m_vx[dst] = m_vx[src]; m_vy[dst] = m_vy[src]; m_vz[dst] = m_vz[src];
    m_life[dst] = m_life[src]; m_full[dst] = m_full[src];
    m_color[dst] = m_color[src];
  endfunction

  // Euler step over the whole pool, with swap-remove of dead particles.
  function automatic void advance_pool(input longint dt);
    int i;
    int lf, vy;
    i = 0;
    while (i < live) begin
      lf = clamp32(longint'(m_life[i]) - dt);
      m_life[i] = lf;
      if (lf <= 0) begin
        if (i + 1 < live) move_particle(i, live - 1);
        live--;
        continue;
      end
      m_vx[i] = clamp32(m_vx[i] + qprod(grav_x, dt));
      m_vy[i] = clamp32(m_vy[i] + qprod(grav_y, dt));
      m_vz[i] = clamp32(m_vz[i] + qprod(grav_z, dt));
      m_px[i] = clamp32(m_px[i] + qprod(m_vx[i], dt));
      m_py[i] = clamp32(m_py[i] + qprod(m_vy[i], dt));
      m_pz[i] = clamp32(m_pz[i] + qprod(m_vz[i], dt));
      if (m_py[i] <= ground) begin
        m_py[i] = ground;
        vy = clamp32(qprod(-longint'(m_vy[i]), longint'(damping)));
        if (vy > -ppe_pkg::HalfQ && vy < ppe_pkg::HalfQ) vy = 0;
        m_vy[i] = vy;
      end
      m_color[i] = age_color(lf, m_full[i]);
      i++;
    end
  endfunction

  // Result of one accepted item; updates the mirror.
  function automatic particle_reply_t pool_reply(input stim_row_t r);
    particle_reply_t x;
    int unsigned lim;
    int s;
    x = '{default: '0};
    case (r.op)
      ppe_pkg::OP_SPAWN: begin
        n_spawn++;
        lim = (limit_reg > ppe_pkg::PoolCapacity) ? ppe_pkg::PoolCapacity : limit_reg;
        if (live >= lim) begin
          x.status = ppe_pkg::ST_FULL;
          n_full++;
        end else begin
          m_px[live] = r.px; m_py[live] = r.py; m_pz[live] = r.pz;
          m_vx[live] = r.vx; m_vy[live] = r.vy; m_vz[live] = r.vz;
          m_life[live] = int'({1'b0, r.lt});
          m_full[live] = int'({1'b0, r.lt});
          m_color[live] = color_birth;
          live++;
        end
      end
      ppe_pkg::OP_TICK: begin
        n_tick++;
        advance_pool(longint'(r.dt));
      end
      ppe_pkg::OP_READ: begin
        n_read++;
        s = int'(r.slot);
        if (s >= live) begin
          x.status = ppe_pkg::ST_NOT_LIVE;
        end else begin
          x.pos_x = m_px[s]; x.pos_y = m_py[s]; x.pos_z = m_pz[s];
          x.vel_x = m_vx[s]; x.vel_y = m_vy[s]; x.vel_z = m_vz[s];
          x.life = m_life[s];
          x.color = m_color[s];
        end
      end
      default: ;
    endcase
    x.live_count = 11'(live);
    return x;
  endfunction

  function automatic stim_row_t mk(input logic [1:0] op, input int slot,
                                   input int px, input int py, input int pz,
                                   input int vx, input int vy, input int vz,
                                   input int lt, input int dt,
                                   input bit he, input logic [1:0] st,
                                   input int cnt);
    stim_row_t r;
    r.op = op; r.slot = 10'(slot);
    r.px = px; r.py = py; r.pz = pz; r.vx = vx; r.vy = vy; r.vz = vz;
    r.lt = 31'(lt); r.dt = 31'(dt);
    r.has_exp = he; r.st = st; r.cnt = cnt;
    return r;
  endfunction

  // Watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls, a long hold-off on request, checks.
  initial begin
    particle_reply_t e;
    int stall;
    int hold;
    bit hold_taken;
    out_tready = 1'b0;
    stall = 0;
    hold = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        checked++;
        if (replies_due.size() == 0) begin
          $error("result transfer with no expectation waiting");
          failures++;
        end else begin
          e = replies_due.pop_front();
          if (out_tdata[1:0] !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_tdata[1:0]);
            failures++;
          end
          if (out_tdata[12:2] !== e.live_count) begin
            $error("live_count: expected %0d, got %0d", e.live_count, out_tdata[12:2]);
            failures++;
          end
          if (out_tdata[44:13] !== e.pos_x) begin
            $error("out_pos_x: expected %h, got %h", e.pos_x, out_tdata[44:13]);
            failures++;
          end
          if (out_tdata[76:45] !== e.pos_y) begin
            $error("out_pos_y: expected %h, got %h", e.pos_y, out_tdata[76:45]);
            failures++;
          end
          if (out_tdata[108:77] !== e.pos_z) begin
            $error("out_pos_z: expected %h, got %h", e.pos_z, out_tdata[108:77]);
            failures++;
          end
          if (out_tdata[140:109] !== e.vel_x) begin
            $error("out_vel_x: expected %h, got %h", e.vel_x, out_tdata[140:109]);
            failures++;
          end
          if (out_tdata[172:141] !== e.vel_y) begin
            $error("out_vel_y: expected %h, got %h", e.vel_y, out_tdata[172:141]);
            failures++;
          end
          if (out_tdata[204:173] !== e.vel_z) begin
            $error("out_vel_z: expected %h, got %h", e.vel_z, out_tdata[204:173]);
            failures++;
          end
          if (out_tdata[236:205] !== e.life) begin
            $error("out_life: expected %h, got %h", e.life, out_tdata[236:205]);
            failures++;
          end
          if (out_tdata[300:237] !== e.color) begin
            $error("out_color: expected %h, got %h", e.color, out_tdata[300:237]);
            failures++;
          end
        end
      end
      // Pick readiness for the next edge.
      if (hold_req && !hold_taken) begin
        hold = 400;
        hold_taken = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        out_tready <= (stall == 0);
      end
    end
  end

  // Configuration write, only with the block idle; the caller drops valid.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ppe_pkg::REG_GRAV_X: grav_x = int'(val[31:0]);
      ppe_pkg::REG_GRAV_Y: grav_y = int'(val[31:0]);
      ppe_pkg::REG_GRAV_Z: grav_z = int'(val[31:0]);
      ppe_pkg::REG_GROUND: ground = int'(val[31:0]);
      ppe_pkg::REG_DAMPING: damping = val[16:0];
      ppe_pkg::REG_START_COLOR: color_birth = val;
      ppe_pkg::REG_END_COLOR: color_death = val;
      default: limit_reg = val[10:0];
    endcase
  endtask

  task automatic set_phase(input int gx, input int gy, input int gz, input int gnd,
                           input int damp, input logic [63:0] sc,
                           input logic [63:0] ec, input int lim);
    wait (replies_due.size() == 0);
    repeat (60) @(posedge clk);
    write_reg(ppe_pkg::REG_GRAV_X, 64'(unsigned'(gx)));
    write_reg(ppe_pkg::REG_GRAV_Y, 64'(unsigned'(gy)));
    write_reg(ppe_pkg::REG_GRAV_Z, 64'(unsigned'(gz)));
    write_reg(ppe_pkg::REG_GROUND, 64'(unsigned'(gnd)));
    write_reg(ppe_pkg::REG_DAMPING, 64'(damp));
    write_reg(ppe_pkg::REG_START_COLOR, sc);
    write_reg(ppe_pkg::REG_END_COLOR, ec);
    write_reg(ppe_pkg::REG_POOL_LIMIT, 64'(lim));
    cfg_valid <= 1'b0;
  endtask

  // Offers one item; the mirror is updated at the transfer.
  task automatic send_item(input stim_row_t r);
    particle_reply_t x;
    int gap;
    in_tdata <= {6'b0, r.dt, r.lt, r.vz, r.vy, r.vx, r.pz, r.py, r.px, r.slot, r.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    x = pool_reply(r);
    if (r.has_exp) begin
      x.status = r.st;
      x.live_count = 11'(r.cnt);
    end
    replies_due.insert(replies_due.size(), x);
    gap = 0;
    if ($urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly plausible flight values, now and then the full range.
  function automatic int rand_q(input int span);
    if ($urandom_range(0, 7) == 0) return int'($urandom());
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic stim_row_t rand_item();
    stim_row_t r;
    int k;
    k = $urandom_range(0, 99);
    r = mk(ppe_pkg::OP_SPAWN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ppe_pkg::ST_OK, 0);
    if (k < 35) r.op = ppe_pkg::OP_SPAWN;
    else if (k < 60) r.op = ppe_pkg::OP_TICK;
    else if (k < 95) r.op = ppe_pkg::OP_READ;
    else r.op = 2'd3;
    r.slot = ($urandom_range(0, 5) == 0) ? 10'($urandom()) : 10'($urandom_range(0, live + 1));
    r.px = rand_q(100 * ppe_pkg::QOne);
    r.py = rand_q(100 * ppe_pkg::QOne);
    r.pz = rand_q(100 * ppe_pkg::QOne);
    r.vx = rand_q(20 * ppe_pkg::QOne);
    r.vy = rand_q(20 * ppe_pkg::QOne);
    r.vz = rand_q(20 * ppe_pkg::QOne);
    r.lt = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                       : 31'($urandom_range(0, 5 * ppe_pkg::QOne));
    r.dt = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                       : 31'($urandom_range(0, ppe_pkg::QOne / 4));
    return r;
  endfunction

  // Stimulus.
  initial begin
    stim_row_t rows[$];
    localparam int MaxI = 32'h7FFF_FFFF;
    localparam int MinI = 32'h8000_0000;
    localparam int Q1 = ppe_pkg::QOne;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    failures = 0; checked = 0;
    n_spawn = 0; n_tick = 0; n_read = 0; n_full = 0;
    grav_x = 0; grav_y = -983040; grav_z = 0; ground = 0;
    damping = 32768; limit_reg = 1000;
    color_birth = 64'hFFFF7FFF3333FFFF;
    color_death = 64'h33333333FFFF0000;
    live = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings.
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                1, ppe_pkg::ST_NOT_LIVE, 0));
    rows.insert(rows.size(), mk(2'd3, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 1, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                1, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_SPAWN, 0, MaxI, MaxI, MaxI, MaxI, MaxI, MaxI,
                                MaxI, 0, 1, ppe_pkg::ST_OK, 1));
    rows.insert(rows.size(), mk(ppe_pkg::OP_SPAWN, 0, MinI, MinI, MinI, MinI, MinI, MinI,
                                0, 0, 1, ppe_pkg::ST_OK, 2));
    rows.insert(rows.size(), mk(ppe_pkg::OP_SPAWN, 0, 0, 3 * Q1, 0, Q1, 0, -Q1, 1, 0,
                                1, ppe_pkg::ST_OK, 3));
    rows.insert(rows.size(), mk(ppe_pkg::OP_SPAWN, 0, Q1, -Q1, 2 * Q1, 0, 10000, 0, 4 * Q1,
                                0, 1, ppe_pkg::ST_OK, 4));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0,
                                1, ppe_pkg::ST_NOT_LIVE, 4));
    rows.insert(rows.size(), mk(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, Q1 / 2,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, MaxI,
                                0, ppe_pkg::ST_OK, 0));
    rows.insert(rows.size(), mk(ppe_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, ppe_pkg::ST_OK, 0));
    foreach (rows[i]) send_item(rows[i]);
    in_tvalid <= 1'b0;

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_phase(0, -983040, 0, 0, 32768, 64'hFFFF7FFF3333FFFF,
                     64'h33333333FFFF0000, 8);
        1: set_phase(MaxI, MinI, MinI, MinI, 0, 64'h0, 64'hFFFFFFFFFFFFFFFF, 1);
        2: set_phase(MinI, MaxI, MaxI, MaxI, Q1, 64'hFFFFFFFFFFFFFFFF, 64'h0, 2047);
        3: set_phase(rand_q(20 * Q1), rand_q(20 * Q1), rand_q(20 * Q1),
                     rand_q(5 * Q1), 131071, {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, 0);
        4: set_phase(rand_q(20 * Q1), -983040, rand_q(20 * Q1), rand_q(5 * Q1),
                     $urandom_range(0, 131071), {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, 16);
        default: set_phase(0, -983040, 0, 0, 49152, {$urandom(), $urandom()},
                           {$urandom(), $urandom()}, 1024);
      endcase
      for (int n = 0; n < 45; n++) begin
        if (ph == 5 && n == 10) hold_req = 1'b1;
        send_item(rand_item());
      end
      in_tvalid <= 1'b0;
    end

    wait (replies_due.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d spawns (%0d refused), %0d ticks, %0d reads; %0d results checked.",
             n_spawn, n_full, n_tick, n_read, checked);
    $display("Register phases: reset values, gravity and ground extremes, damping 0..max.");
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* particle_pool_euler_update.f */
sv/ppe_pkg.sv
sv/ppe_ram.sv
sv/ppe_alu.sv
sv/ppe_div.sv
sv/particle_pool_euler_update.sv
dv/testbench.sv
